// ===== rtl/core/azlc_pkg.sv =====
// shared types and constants of the alarm zone loop classifier
// no dependencies; all other files but azlc_stream_if refer to it by scoped names
package azlc_pkg;

  localparam int unsigned ZONE_W      = 4;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned MV_W        = 11;
  localparam int unsigned STATE_W     = 3;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned MASK_ZONES  = 10;
  localparam int unsigned ZONE_SLOTS  = 16;
  localparam int unsigned REG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 33;

  localparam int unsigned MASK_W   = MASK_ZONES;
  localparam int unsigned MAP_W    = MODE_W * MASK_ZONES;
  localparam int unsigned SINGLE_W = 2 * MV_W;
  localparam int unsigned TIERS_W  = 3 * MV_W;

  localparam logic [MASK_W-1:0]   ENABLE_RESET = 10'h3FF;
  localparam logic [MAP_W-1:0]    MAP_RESET    = 20'h55555;
  localparam logic [SINGLE_W-1:0] SINGLE_RESET = 22'd1802328;
  localparam logic [TIERS_W-1:0]  DOUBLE_RESET = 33'd3692114030;
  localparam logic [TIERS_W-1:0]  TRIPLE_RESET = 33'd3322744909;

  // mv = floor(sample * 1100 / 4095) as (sample * MV_RECIP) >> MV_SHIFT, exact for 12-bit input
  localparam int unsigned MV_SCALE   = 1100;
  localparam int unsigned ADC_FULL   = 4095;
  localparam int unsigned MV_SHIFT   = 24;
  localparam int unsigned MV_RECIP_W = 23;
  localparam int unsigned MV_PROD_W  = SAMPLE_W + MV_RECIP_W;
  localparam logic [63:0] MV_RECIP_FULL =
    ((64'(MV_SCALE) << MV_SHIFT) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL);
  localparam logic [MV_RECIP_W-1:0] MV_RECIP = MV_RECIP_W'(MV_RECIP_FULL);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef enum logic [STATE_W-1:0] {
    ST_NORMAL  = 3'd0,
    ST_ALARM   = 3'd1,
    ST_TAMPER  = 3'd2,
    ST_MASKING = 3'd3,
    ST_FAULT   = 3'd4
  } zone_state_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINGLE     = 2'd0,
    MODE_DOUBLE     = 2'd1,
    MODE_TRIPLE     = 2'd2,
    MODE_TRIPLE_ALT = 2'd3
  } loop_mode_e;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_MODE   = 3'd1,
    REG_SINGLE = 3'd2,
    REG_DOUBLE = 3'd3,
    REG_TRIPLE = 3'd4
  } reg_index_e;

  typedef struct packed {
    logic [ZONE_W-1:0]   zone;
    logic [SAMPLE_W-1:0] sample;
    logic                read_error;
  } in_item_t;

  typedef struct packed {
    logic [ZONE_W-1:0]  zone_out;
    logic [MV_W-1:0]    avg_mv;
    logic [STATE_W-1:0] zone_state;
  } out_item_t;

  typedef struct packed {
    logic [REG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wdata;
  } cfg_write_t;

  typedef struct packed {
    logic [MASK_W-1:0]   enable_mask;
    logic [MAP_W-1:0]    mode_map;
    logic [SINGLE_W-1:0] single_limits;
    logic [TIERS_W-1:0]  double_limits;
    logic [TIERS_W-1:0]  triple_limits;
  } cfg_t;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [MV_W-1:0]   mv;
    logic [MODE_W-1:0] mode;
    logic              fault;
  } queue_entry_t;

endpackage

// ===== rtl/core/azlc_stream_if.sv =====
// valid/ready channel with a typed payload, used for sample, result and register write channels
// payload types come from azlc_pkg
interface azlc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/azlc_cfg_regs.sv =====
// configuration registers of the zone classifier, written through the register write channel
// depends on azlc_pkg and azlc_stream_if
module azlc_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  azlc_stream_if.sink          cfg_i,
  output azlc_pkg::cfg_t       cfg_o
);

  azlc_pkg::cfg_t cfg_q, cfg_d;
  logic           write;

  assign cfg_i.ready = 1'b1;
  assign write = cfg_i.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (write) begin
      case (cfg_i.payload.reg_index)
        azlc_pkg::REG_ENABLE:
          cfg_d.enable_mask = cfg_i.payload.wdata[azlc_pkg::MASK_W-1:0];
        azlc_pkg::REG_MODE:
          cfg_d.mode_map = cfg_i.payload.wdata[azlc_pkg::MAP_W-1:0];
        azlc_pkg::REG_SINGLE:
          cfg_d.single_limits = cfg_i.payload.wdata[azlc_pkg::SINGLE_W-1:0];
        azlc_pkg::REG_DOUBLE:
          cfg_d.double_limits = cfg_i.payload.wdata[azlc_pkg::TIERS_W-1:0];
        azlc_pkg::REG_TRIPLE:
          cfg_d.triple_limits = cfg_i.payload.wdata[azlc_pkg::TIERS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_mask   <= azlc_pkg::ENABLE_RESET;
      cfg_q.mode_map      <= azlc_pkg::MAP_RESET;
      cfg_q.single_limits <= azlc_pkg::SINGLE_RESET;
      cfg_q.double_limits <= azlc_pkg::DOUBLE_RESET;
      cfg_q.triple_limits <= azlc_pkg::TRIPLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/azlc_front.sv =====
// front end: takes samples, drops unknown zones, scales to millivolts and marks fault items
// depends on azlc_pkg and azlc_stream_if; feeds azlc_queue
module azlc_front #(
  parameter int unsigned ZONES = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  azlc_stream_if.sink            in_i,
  input  azlc_pkg::cfg_t         cfg_i,
  input  logic                   full_i,
  output logic                   push_o,
  output azlc_pkg::queue_entry_t entry_o
);

  logic                                  valid_q, valid_d;
  logic [azlc_pkg::ZONE_W-1:0]           zone_q;
  logic [azlc_pkg::MV_PROD_W-1:0]        prod_q;
  logic [azlc_pkg::MODE_W-1:0]           mode_q;
  logic                                  fault_q;
  logic                                  accept;
  logic                                  in_range;
  logic                                  enabled;
  logic [azlc_pkg::ZONE_SLOTS-1:0]       enable_ext;
  logic [azlc_pkg::ZONE_SLOTS-1:0][azlc_pkg::MODE_W-1:0] mode_ext;

  assign enable_ext = azlc_pkg::ZONE_SLOTS'(cfg_i.enable_mask);
  assign mode_ext   = (azlc_pkg::ZONE_SLOTS * azlc_pkg::MODE_W)'(cfg_i.mode_map);

  assign in_range = {1'b0, in_i.payload.zone} < (azlc_pkg::ZONE_W + 1)'(ZONES);
  assign enabled  = enable_ext[in_i.payload.zone];

  assign in_i.ready = !valid_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = in_range;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      zone_q  <= in_i.payload.zone;
      prod_q  <= azlc_pkg::MV_PROD_W'(in_i.payload.sample) *
                 azlc_pkg::MV_PROD_W'(azlc_pkg::MV_RECIP);
      mode_q  <= mode_ext[in_i.payload.zone];
      fault_q <= !enabled || in_i.payload.read_error;
    end
  end

  assign entry_o.zone  = zone_q;
  assign entry_o.mv    = prod_q[azlc_pkg::MV_SHIFT +: azlc_pkg::MV_W];
  assign entry_o.mode  = mode_q;
  assign entry_o.fault = fault_q;

endmodule

// ===== rtl/core/azlc_queue.sv =====
// short first-in first-out queue between front and back end
// depends on azlc_pkg
module azlc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  azlc_pkg::queue_entry_t entry_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output azlc_pkg::queue_entry_t entry_o
);

  azlc_pkg::queue_entry_t              mem_q [azlc_pkg::QUEUE_DEPTH];
  logic [azlc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [azlc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [azlc_pkg::QUEUE_CNT_W-1:0]    count_q, count_d;

  assign full_o  = count_q == azlc_pkg::QUEUE_CNT_W'(azlc_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/azlc_back.sv =====
// back end: per-zone burst accumulation, average by reciprocal multiply, loop classification
// depends on azlc_pkg and azlc_stream_if; drains azlc_queue
module azlc_back #(
  parameter int unsigned ZONES     = 10,
  parameter int unsigned BURST_LEN = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  azlc_pkg::queue_entry_t entry_i,
  output logic                   pop_o,
  input  azlc_pkg::cfg_t         cfg_i,
  azlc_stream_if.source          out_o
);

  localparam int unsigned ZIDX_W  = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned CNT_W   = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
  localparam int unsigned SUM_W   = $clog2(azlc_pkg::MV_SCALE * BURST_LEN + 1);
  localparam int unsigned SHIFT   = SUM_W + $clog2(BURST_LEN);
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(BURST_LEN) - 64'd1) / 64'(BURST_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [SUM_W-1:0] sum_q [ZONES];
  logic [CNT_W-1:0] cnt_q [ZONES];

  logic                          advance;
  logic [ZIDX_W-1:0]             idx;
  logic [SUM_W-1:0]              sum_new;
  logic [CNT_W:0]                cnt_new;
  logic                          complete;
  logic                          clear;

  logic                          s2_valid_q;
  logic [azlc_pkg::ZONE_W-1:0]   s2_zone_q;
  logic [SUM_W-1:0]              s2_sum_q;
  logic [azlc_pkg::MODE_W-1:0]   s2_mode_q;
  logic                          s2_fault_q;

  logic                          s3_valid_q;
  logic [azlc_pkg::ZONE_W-1:0]   s3_zone_q;
  logic [PROD_W-1:0]             s3_prod_q;
  logic [azlc_pkg::MODE_W-1:0]   s3_mode_q;
  logic                          s3_fault_q;

  logic                          out_valid_q;
  azlc_pkg::out_item_t           out_q, out_d;
  logic [azlc_pkg::MV_W-1:0]     avg;

  function automatic logic [azlc_pkg::STATE_W-1:0] classify(
    input logic [azlc_pkg::MODE_W-1:0] mode,
    input logic [azlc_pkg::MV_W-1:0]   v,
    input azlc_pkg::cfg_t              cfg
  );
    logic [azlc_pkg::TIERS_W-1:0]  tiers;
    logic [azlc_pkg::STATE_W-1:0]  top;
    logic [azlc_pkg::STATE_W-1:0]  res;
    tiers = cfg.double_limits;
    top   = azlc_pkg::ST_TAMPER;
    res   = azlc_pkg::ST_NORMAL;
    case (mode)
      azlc_pkg::MODE_SINGLE: begin
        tiers = '0;
      end
      azlc_pkg::MODE_DOUBLE: begin
        tiers = cfg.double_limits;
        top   = azlc_pkg::ST_TAMPER;
      end
      default: begin
        tiers = cfg.triple_limits;
        top   = azlc_pkg::ST_MASKING;
      end
    endcase
    if (mode == azlc_pkg::MODE_SINGLE) begin
      if (v < cfg.single_limits[0 +: azlc_pkg::MV_W]) begin
        res = azlc_pkg::ST_FAULT;
      end else if (v > cfg.single_limits[azlc_pkg::MV_W +: azlc_pkg::MV_W]) begin
        res = azlc_pkg::ST_ALARM;
      end else begin
        res = azlc_pkg::ST_NORMAL;
      end
    end else begin
      if (v < tiers[0 +: azlc_pkg::MV_W]) begin
        res = azlc_pkg::ST_TAMPER;
      end else if (v <= tiers[azlc_pkg::MV_W +: azlc_pkg::MV_W]) begin
        res = azlc_pkg::ST_NORMAL;
      end else if (v <= tiers[2 * azlc_pkg::MV_W +: azlc_pkg::MV_W]) begin
        res = azlc_pkg::ST_ALARM;
      end else begin
        res = top;
      end
    end
    return res;
  endfunction

  assign advance = !out_valid_q || out_o.ready;
  assign pop_o   = valid_i && advance;

  assign idx      = entry_i.zone[ZIDX_W-1:0];
  assign sum_new  = sum_q[idx] + SUM_W'(entry_i.mv);
  assign cnt_new  = {1'b0, cnt_q[idx]} + 1'b1;
  assign complete = cnt_new == (CNT_W + 1)'(BURST_LEN);
  assign clear    = entry_i.fault || complete;

  // per-zone burst state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ZONES; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (pop_o) begin
      if (clear) begin
        sum_q[idx] <= '0;
        cnt_q[idx] <= '0;
      end else begin
        sum_q[idx] <= sum_new;
        cnt_q[idx] <= cnt_new[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q  <= pop_o && clear;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  assign avg = s3_prod_q[SHIFT +: azlc_pkg::MV_W];

  always_comb begin
    out_d.zone_out = s3_zone_q;
    if (s3_fault_q) begin
      out_d.avg_mv     = '0;
      out_d.zone_state = azlc_pkg::ST_FAULT;
    end else begin
      out_d.avg_mv     = avg;
      out_d.zone_state = classify(s3_mode_q, avg, cfg_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_zone_q  <= entry_i.zone;
      s2_sum_q   <= sum_new;
      s2_mode_q  <= entry_i.mode;
      s2_fault_q <= entry_i.fault;
      s3_zone_q  <= s2_zone_q;
      s3_prod_q  <= PROD_W'(s2_sum_q) * PROD_W'(RECIP);
      s3_mode_q  <= s2_mode_q;
      s3_fault_q <= s2_fault_q;
      out_q      <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// ===== rtl/core/alarm_zone_loop_classifier_top.sv =====
// Alarm zone loop classifier, top level.
// Channels: in_i takes one converter sample per transfer (zone, sample, read_error);
// out_o gives one classification per transfer (zone_out, avg_mv, zone_state);
// cfg_i writes one configuration register per transfer, index 0 to 4, always ready.
// A sample of a zone at or above ZONES is taken and dropped. A sample of a disabled
// zone or with read_error set yields fault with 0 mV and restarts the zone's burst.
// Otherwise the BURST_LEN-th sample of a zone yields its average and loop state.
// Throughput: one sample per cycle while out_o takes results, set by the per-zone
// read-modify-write of the burst registers in the back end.
// A result passes from the transfer of the sample that causes it through the
// input register, a 4-entry queue, the accumulate stage, the average multiply
// stage and the output register.
// Reset clears all bursts and the queue and loads the register defaults; it takes
// effect at once, with no clearing pass.
// When the receiver stalls, the back end holds; the queue then fills and in_i
// drops ready only after the front register and all queue entries are taken.
module alarm_zone_loop_classifier_top #(
  parameter int unsigned ZONES     = 10,
  parameter int unsigned BURST_LEN = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  azlc_stream_if.sink   in_i,
  azlc_stream_if.source out_o,
  azlc_stream_if.sink   cfg_i
);

  azlc_pkg::cfg_t         cfg;
  azlc_pkg::queue_entry_t push_entry;
  azlc_pkg::queue_entry_t head_entry;
  logic                   push;
  logic                   full;
  logic                   head_valid;
  logic                   pop;

  azlc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  azlc_front #(
    .ZONES (ZONES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  azlc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .entry_o (head_entry)
  );

  azlc_back #(
    .ZONES     (ZONES),
    .BURST_LEN (BURST_LEN)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .cfg_i   (cfg),
    .out_o   (out_o)
  );

endmodule
